### src/uhed_pkg.sv
package uhed_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned LEN_W      = 16;
  localparam int unsigned HLEN_W     = 6;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  // most output bytes a single input byte can cause
  localparam int unsigned NRES       = 9;
  localparam int unsigned CNT_W      = $clog2(NRES + 1);

  localparam logic [LEN_W-1:0]  UDP_HDR_BYTES = 16'd8;
  localparam logic [LEN_W-1:0]  MAX_LEN       = 16'hFFFF;
  localparam logic [HLEN_W-1:0] IPV6_HDR_LEN  = 6'd40;
  localparam logic [3:0]        IPV4_MIN_IHL  = 4'd5;
  localparam logic [7:0]        UDP_PROTO     = 8'd17;

  localparam logic             ENCAP_RST    = 1'b1;
  localparam logic             IPVER_RST    = 1'b0;
  localparam logic [7:0]       NEW_PROT_RST = 8'd17;
  localparam logic [LEN_W-1:0] PORT_RST     = 16'd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENCAP_MODE  = 3'd0,
    CFG_IP_VERSION  = 3'd1,
    CFG_NEW_PROT    = 3'd2,
    CFG_SOURCE_PORT = 3'd3,
    CFG_DEST_PORT   = 3'd4
  } cfg_reg_t;

  typedef logic [NRES-1:0][BYTE_W-1:0] res_bytes_t;

  // ones' complement end-around fold of a sum of up to three 16-bit terms
  function automatic logic [LEN_W-1:0] csum_fold(input logic [LEN_W+1:0] s);
    logic [LEN_W:0] t;
    t = {1'b0, s[LEN_W-1:0]} + {15'd0, s[LEN_W+1:LEN_W]};
    return t[LEN_W-1:0] + {15'd0, t[LEN_W]};
  endfunction

endpackage

### src/uhed_in_if.sv
interface uhed_in_if;
  import uhed_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic [LEN_W-1:0]  packet_length;
  logic              last_byte;

  modport source (output valid, output data_byte, output packet_length, output last_byte,
                  input ready);
  modport sink   (input valid, input data_byte, input packet_length, input last_byte,
                  output ready);
endinterface

### src/uhed_out_if.sv
interface uhed_out_if;
  import uhed_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              out_last;
  logic              drop;

  modport source (output valid, output out_byte, output out_last, output drop, input ready);
  modport sink   (input valid, input out_byte, input out_last, input drop, output ready);
endinterface

### src/uhed_cfg_if.sv
interface uhed_cfg_if;
  import uhed_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### src/udp_header_encap_decap_top.sv
// channel   dir  payload                                        handshake
// in_chan   in   data_byte[8] packet_length[16] last_byte[1]    valid/ready
// out_chan  out  out_byte[8] out_last[1] drop[1]                valid/ready
// cfg_chan  in   index[3] data[16]                              valid/ready (always ready)
//
// one input byte is taken per cycle while no results wait; its 0 to 9 output bytes
// are formed in one pass and held in a small result register that drains one byte
// per cycle while out ready; several results stall the input while they drain: at
// the encap header-closing byte and at a length or checksum byte, none elsewhere
// synchronous active-low reset clears the packet state and the config registers
// the next byte is taken in the cycle the last pending result is taken
module udp_header_encap_decap_top (
  input  logic       clk,
  input  logic       rst_n,
  uhed_in_if.sink    in_chan,
  uhed_out_if.source out_chan,
  uhed_cfg_if.sink   cfg_chan
);
  import uhed_pkg::*;

  localparam logic [LEN_W-1:0] OFF4_LEN_HI  = 16'd2;
  localparam logic [LEN_W-1:0] OFF4_LEN_LO  = 16'd3;
  localparam logic [LEN_W-1:0] OFF4_PROT    = 16'd9;
  localparam logic [LEN_W-1:0] OFF4_CSUM_HI = 16'd10;
  localparam logic [LEN_W-1:0] OFF4_CSUM_LO = 16'd11;
  localparam logic [LEN_W-1:0] OFF6_LEN_HI  = 16'd4;
  localparam logic [LEN_W-1:0] OFF6_LEN_LO  = 16'd5;
  localparam logic [LEN_W-1:0] OFF6_NEXT    = 16'd6;

  // configuration
  logic             encap_r;
  logic             ipv6_r;
  logic [7:0]       new_prot_r;
  logic [LEN_W-1:0] src_port_r;
  logic [LEN_W-1:0] dst_port_r;

  // packet state
  logic [LEN_W-1:0]  byte_offset_r, byte_offset_nxt;
  logic [HLEN_W-1:0] header_length_r, header_length_nxt;
  logic [LEN_W-1:0]  packet_total_r, packet_total_nxt;
  logic [BYTE_W-1:0] held_byte_r, held_byte_nxt;
  logic [LEN_W-1:0]  csum_delta_r, csum_delta_nxt;
  logic              discarding_r, discarding_nxt;

  // result register
  res_bytes_t        res_bytes_r, res_bytes_nxt;
  logic [CNT_W-1:0]  res_cnt_r, res_cnt_nxt;
  logic              res_last_r, res_last_nxt;
  logic              res_drop_r, res_drop_nxt;

  logic in_fire, out_fire, in_rdy;

  logic [BYTE_W-1:0] b;
  logic [LEN_W-1:0]  plen;
  logic              last;
  logic [LEN_W-1:0]  off;
  logic              first;
  logic [HLEN_W-1:0] hlen;
  logic [LEN_W:0]    off17, hl17, off_p1;
  logic              early_drop, in_hdr, special, drop_any;
  logic [LEN_W-1:0]  old_word, new_len, len_delta, prot_delta, csum_new, ulen;

  assign out_fire = out_chan.valid && out_chan.ready;
  assign in_rdy   = (res_cnt_r == '0) || ((res_cnt_r == CNT_W'(1)) && out_chan.ready);
  assign in_fire  = in_chan.valid && in_rdy;

  assign in_chan.ready     = in_rdy;
  assign cfg_chan.ready    = 1'b1;
  assign out_chan.valid    = (res_cnt_r != '0);
  assign out_chan.out_byte = res_bytes_r[0];
  assign out_chan.out_last = res_last_r && (res_cnt_r == CNT_W'(1));
  assign out_chan.drop     = res_drop_r;

  assign b     = in_chan.data_byte;
  assign plen  = in_chan.packet_length;
  assign last  = in_chan.last_byte;
  assign off   = byte_offset_r;
  assign first = (off == '0);

  always_comb begin
    if (!first) begin
      hlen = header_length_r;
    end else if (ipv6_r) begin
      hlen = IPV6_HDR_LEN;
    end else begin
      hlen = {b[3:0], 2'b00};
    end
  end

  assign off17  = {1'b0, off};
  assign hl17   = {{(LEN_W+1-HLEN_W){1'b0}}, hlen};
  assign off_p1 = off17 + 17'd1;
  assign in_hdr = (off17 < hl17);

  always_comb begin
    early_drop = 1'b0;
    if (first) begin
      if (!ipv6_r && (b[3:0] < IPV4_MIN_IHL)) begin
        early_drop = 1'b1;
      end
      if (encap_r) begin
        if (({1'b0, plen} + {1'b0, UDP_HDR_BYTES} > {1'b0, MAX_LEN}) ||
            ({1'b0, plen} < hl17)) begin
          early_drop = 1'b1;
        end
      end else if ({1'b0, plen} < hl17 + {1'b0, UDP_HDR_BYTES}) begin
        early_drop = 1'b1;
      end
    end
  end

  // length word and incremental checksum (delta folded ahead of the checksum bytes)
  assign old_word   = {held_byte_r, b};
  assign new_len    = encap_r ? old_word + UDP_HDR_BYTES : old_word - UDP_HDR_BYTES;
  assign len_delta  = csum_fold({2'b00, ~old_word} + {2'b00, new_len});
  assign prot_delta = csum_fold({2'b00, csum_delta_r} + {2'b00, ~{8'h00, b}} +
                                {10'd0, new_prot_r});
  assign csum_new   = ~csum_fold({2'b00, ~old_word} + {2'b00, csum_delta_r});
  assign ulen       = packet_total_r + UDP_HDR_BYTES - {{(LEN_W-HLEN_W){1'b0}}, hlen};

  always_comb begin
    res_bytes_nxt     = '0;
    res_cnt_nxt       = '0;
    res_last_nxt      = 1'b0;
    res_drop_nxt      = 1'b0;
    held_byte_nxt     = held_byte_r;
    csum_delta_nxt    = csum_delta_r;
    header_length_nxt = header_length_r;
    packet_total_nxt  = packet_total_r;
    discarding_nxt    = discarding_r;
    byte_offset_nxt   = byte_offset_r;
    special           = 1'b0;
    drop_any          = 1'b0;

    if (discarding_r) begin
      if (last) begin
        discarding_nxt  = 1'b0;
        byte_offset_nxt = '0;
      end
    end else begin
      if (first) begin
        packet_total_nxt  = plen;
        header_length_nxt = hlen;
      end
      drop_any = early_drop;
      if (!early_drop) begin
        if (in_hdr && !ipv6_r) begin
          special = 1'b1;
          if ((off == OFF4_LEN_HI) || (off == OFF4_CSUM_HI)) begin
            held_byte_nxt = b;
          end else if (off == OFF4_LEN_LO) begin
            res_bytes_nxt[0] = new_len[15:8];
            res_bytes_nxt[1] = new_len[7:0];
            res_cnt_nxt      = CNT_W'(2);
            csum_delta_nxt   = len_delta;
          end else if (off == OFF4_PROT) begin
            if (!encap_r && (b != UDP_PROTO)) begin
              drop_any = 1'b1;
            end else begin
              res_bytes_nxt[0] = new_prot_r;
              res_cnt_nxt      = CNT_W'(1);
            end
            // protocol term only joins the checksum when the byte changes
            if (b != new_prot_r) begin
              csum_delta_nxt = prot_delta;
            end
          end else if (off == OFF4_CSUM_LO) begin
            res_bytes_nxt[0] = csum_new[15:8];
            res_bytes_nxt[1] = csum_new[7:0];
            res_cnt_nxt      = CNT_W'(2);
          end else begin
            special = 1'b0;
          end
        end else if (in_hdr && ipv6_r) begin
          special = 1'b1;
          if (off == OFF6_LEN_HI) begin
            held_byte_nxt = b;
          end else if (off == OFF6_LEN_LO) begin
            res_bytes_nxt[0] = new_len[15:8];
            res_bytes_nxt[1] = new_len[7:0];
            res_cnt_nxt      = CNT_W'(2);
          end else if (off == OFF6_NEXT) begin
            if (!encap_r && (b != UDP_PROTO)) begin
              drop_any = 1'b1;
            end else begin
              res_bytes_nxt[0] = new_prot_r;
              res_cnt_nxt      = CNT_W'(1);
            end
          end else begin
            special = 1'b0;
          end
        end

        if (!special) begin
          if (encap_r) begin
            res_bytes_nxt[0] = b;
            res_cnt_nxt      = CNT_W'(1);
            if (off_p1 == hl17) begin
              res_bytes_nxt[1] = src_port_r[15:8];
              res_bytes_nxt[2] = src_port_r[7:0];
              res_bytes_nxt[3] = dst_port_r[15:8];
              res_bytes_nxt[4] = dst_port_r[7:0];
              res_bytes_nxt[5] = ulen[15:8];
              res_bytes_nxt[6] = ulen[7:0];
              res_bytes_nxt[7] = '0;
              res_bytes_nxt[8] = '0;
              res_cnt_nxt      = CNT_W'(NRES);
            end
          end else if (off_p1 < hl17) begin
            res_bytes_nxt[0] = b;
            res_cnt_nxt      = CNT_W'(1);
          end else if (off_p1 == hl17) begin
            held_byte_nxt = b;
          end else if (off17 == hl17 + 17'd7) begin
            // last header byte goes out with the final stripped byte
            res_bytes_nxt[0] = held_byte_r;
            res_cnt_nxt      = CNT_W'(1);
          end else if (off17 > hl17 + 17'd7) begin
            res_bytes_nxt[0] = b;
            res_cnt_nxt      = CNT_W'(1);
          end
        end

        // truncated before the header end or before the stripped header end
        if (last && (encap_r ? (off_p1 < hl17) : (off17 < hl17 + 17'd7))) begin
          drop_any = 1'b1;
        end
      end

      if (drop_any) begin
        res_bytes_nxt   = '0;
        res_cnt_nxt     = CNT_W'(1);
        res_last_nxt    = 1'b1;
        res_drop_nxt    = 1'b1;
        discarding_nxt  = !last;
        byte_offset_nxt = '0;
      end else if (last) begin
        res_last_nxt    = 1'b1;
        byte_offset_nxt = '0;
      end else if (off != MAX_LEN) begin
        byte_offset_nxt = off + 16'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      encap_r    <= ENCAP_RST;
      ipv6_r     <= IPVER_RST;
      new_prot_r <= NEW_PROT_RST;
      src_port_r <= PORT_RST;
      dst_port_r <= PORT_RST;
    end else if (cfg_chan.valid) begin
      case (cfg_chan.index)
        CFG_ENCAP_MODE:  encap_r    <= cfg_chan.data[0];
        CFG_IP_VERSION:  ipv6_r     <= cfg_chan.data[0];
        CFG_NEW_PROT:    new_prot_r <= cfg_chan.data[7:0];
        CFG_SOURCE_PORT: src_port_r <= cfg_chan.data;
        CFG_DEST_PORT:   dst_port_r <= cfg_chan.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_offset_r   <= '0;
      header_length_r <= '0;
      packet_total_r  <= '0;
      held_byte_r     <= '0;
      csum_delta_r    <= '0;
      discarding_r    <= 1'b0;
    end else if (in_fire) begin
      byte_offset_r   <= byte_offset_nxt;
      header_length_r <= header_length_nxt;
      packet_total_r  <= packet_total_nxt;
      held_byte_r     <= held_byte_nxt;
      csum_delta_r    <= csum_delta_nxt;
      discarding_r    <= discarding_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_cnt_r <= '0;
    end else if (in_fire) begin
      res_cnt_r <= res_cnt_nxt;
    end else if (out_fire) begin
      res_cnt_r <= res_cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_bytes_r <= res_bytes_nxt;
      res_last_r  <= res_last_nxt;
      res_drop_r  <= res_drop_nxt;
    end else if (out_fire) begin
      res_bytes_r <= res_bytes_t'(res_bytes_r >> BYTE_W);
    end
  end

endmodule

### src/uhed_checker.sv
module uhed_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       out_last,
  input logic       out_drop
);

  // a drop request stands alone and closes the packet
  a_drop_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_drop |-> out_last && (out_byte == 8'h00))
    else $error("drop request without last or with non-zero byte");

  // nothing pending means the input side is open
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with no result pending");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result shown straight after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_last) &&
                                $stable(out_drop))
    else $error("stalled result changed");

endmodule

bind udp_header_encap_decap_top uhed_checker u_uhed_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_byte  (out_chan.out_byte),
  .out_last  (out_chan.out_last),
  .out_drop  (out_chan.drop)
);

### sim/tb_top.sv
module tb_top;
  import uhed_pkg::*;

  typedef struct packed {
    logic [BYTE_W-1:0] obyte;
    logic              olast;
    logic              odrop;
  } result_t;

  typedef enum logic {ROW_CFG, ROW_BYTE} row_kind_t;

  typedef struct packed {
    row_kind_t        kind;
    cfg_reg_t         reg_idx;
    logic [15:0]      val;
    logic [7:0]       b;
    logic [LEN_W-1:0] plen;
    logic             lst;
    logic             typed;
    result_t          res;
  } step_row_t;

  localparam result_t DROP_RES = '{8'h00, 1'b1, 1'b1};
  localparam result_t NO_RES   = '0;
  localparam int      N_ROWS   = 23;
  localparam int      N_PHASES = 6;
  localparam int      HOLD_CYCLES = 300;

  // directed requests; a typed result replaces the predicted one
  localparam step_row_t DIR_ROWS [N_ROWS] = '{
    '{ROW_BYTE, CFG_ENCAP_MODE, 16'h0, 8'h44, 16'd100,  1'b0, 1'b1, DROP_RES}, // ihl below five
    '{ROW_BYTE, CFG_ENCAP_MODE, 16'h0, 8'hFF, 16'h0000, 1'b1, 1'b0, NO_RES},   // swallowed
    '{ROW_BYTE, CFG_ENCAP_MODE, 16'h0, 8'h45, 16'hFFFF, 1'b1, 1'b1, DROP_RES}, // length overflow
    '{ROW_BYTE, CFG_ENCAP_MODE, 16'h0, 8'h45, 16'hFFF8, 1'b1, 1'b1, DROP_RES},
    '{ROW_BYTE, CFG_ENCAP_MODE, 16'h0, 8'h4F, 16'h0000, 1'b1, 1'b1, DROP_RES}, // shorter than header
    '{ROW_BYTE, CFG_ENCAP_MODE, 16'h0, 8'h45, 16'd20,   1'b1, 1'b1, DROP_RES}, // truncated header
    '{ROW_CFG,  CFG_ENCAP_MODE, 16'h0, 8'h00, 16'h0000, 1'b0, 1'b0, NO_RES},
    '{ROW_BYTE, CFG_ENCAP_MODE, 16'h0, 8'h45, 16'd27,   1'b1, 1'b1, DROP_RES}, // decap underflow
    // decap of a tcp packet, dropped at the protocol byte
    '{ROW_BYTE, CFG_ENCAP_MODE, 16'h0, 8'h45, 16'h0030, 1'b0, 1'b0, NO_RES},
    '{ROW_BYTE, CFG_ENCAP_MODE, 16'h0, 8'h00, 16'hFFFF, 1'b0, 1'b0, NO_RES},
    '{ROW_BYTE, CFG_ENCAP_MODE, 16'h0, 8'h00, 16'h0000, 1'b0, 1'b0, NO_RES},
    '{ROW_BYTE, CFG_ENCAP_MODE, 16'h0, 8'h30, 16'hA5A5, 1'b0, 1'b0, NO_RES},
    '{ROW_BYTE, CFG_ENCAP_MODE, 16'h0, 8'h12, 16'h5A5A, 1'b0, 1'b0, NO_RES},
    '{ROW_BYTE, CFG_ENCAP_MODE, 16'h0, 8'h34, 16'hFFFF, 1'b0, 1'b0, NO_RES},
    '{ROW_BYTE, CFG_ENCAP_MODE, 16'h0, 8'h40, 16'h0000, 1'b0, 1'b0, NO_RES},
    '{ROW_BYTE, CFG_ENCAP_MODE, 16'h0, 8'h00, 16'h1234, 1'b0, 1'b0, NO_RES},
    '{ROW_BYTE, CFG_ENCAP_MODE, 16'h0, 8'h40, 16'hEDCB, 1'b0, 1'b0, NO_RES},
    '{ROW_BYTE, CFG_ENCAP_MODE, 16'h0, 8'h06, 16'h0000, 1'b0, 1'b1, DROP_RES},
    '{ROW_BYTE, CFG_ENCAP_MODE, 16'h0, 8'hAB, 16'hFFFF, 1'b1, 1'b0, NO_RES},
    '{ROW_CFG,  CFG_IP_VERSION, 16'h1, 8'h00, 16'h0000, 1'b0, 1'b0, NO_RES},
    '{ROW_BYTE, CFG_ENCAP_MODE, 16'h0, 8'h60, 16'd47,   1'b1, 1'b1, DROP_RES}, // v6 decap underflow
    '{ROW_CFG,  CFG_ENCAP_MODE, 16'h1, 8'h00, 16'h0000, 1'b0, 1'b0, NO_RES},
    '{ROW_BYTE, CFG_ENCAP_MODE, 16'h0, 8'h60, 16'hFFF8, 1'b1, 1'b1, DROP_RES}  // v6 encap overflow
  };

  logic clk;
  logic rst_n;

  uhed_in_if  in_chan ();
  uhed_out_if out_chan ();
  uhed_cfg_if cfg_chan ();

  udp_header_encap_decap_top uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  // register copies
  logic             mode_encap = ENCAP_RST;
  logic             mode_v6    = IPVER_RST;
  logic [7:0]       prot_cfg   = NEW_PROT_RST;
  logic [LEN_W-1:0] sport_cfg  = PORT_RST;
  logic [LEN_W-1:0] dport_cfg  = PORT_RST;

  // packet state of the rewriter
  logic [LEN_W-1:0]  pos      = '0;
  logic [HLEN_W-1:0] hdr_len  = '0;
  logic [LEN_W-1:0]  old_len  = '0;
  logic [7:0]        old_prot = '0;
  logic [7:0]        held     = '0;
  logic [LEN_W-1:0]  total    = '0;
  logic              skipping = 1'b0;

  result_t step_bytes [$];
  result_t pending_bytes [$];
  result_t seen;
  result_t cur_res;
  logic    cur_typed;

  logic in_acc, cfg_acc;
  int   bytes_taken, mismatches;
  int   snd_idle_pct, rcv_stall_pct;
  logic hold_req;
  int   hold_left;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3000000;
    $display("** udp_header_encap_decap_top: FAILED **");
    $finish;
  end

  // rfc 1624: hc' = ~(~hc + ~m + m')
  function automatic logic [15:0] ones_fix(input logic [15:0] hc, input logic [15:0] m,
                                           input logic [15:0] m2);
    logic [17:0] s;
    s = {2'b00, ~hc} + {2'b00, ~m} + {2'b00, m2};
    s = {2'b00, s[15:0]} + {16'd0, s[17:16]};
    s = {2'b00, s[15:0]} + {16'd0, s[17:16]};
    return ~s[15:0];
  endfunction

  function automatic logic [15:0] len_step(input logic [15:0] old);
    return mode_encap ? old + UDP_HDR_BYTES : old - UDP_HDR_BYTES;
  endfunction

  // works out the bytes one request gives, into step_bytes
  task automatic udp_rewrite(input logic [7:0] b, input logic [LEN_W-1:0] plen, input logic lst);
    int unsigned off, hl, p;
    logic        bad, special;
    logic [15:0] w;
    step_bytes = {};
    bad = 1'b0;
    if (skipping) begin
      if (lst) begin
        skipping = 1'b0;
        pos = '0;
      end
      return;
    end
    off = pos;
    if (off == 0) begin
      total = plen;
      p = plen;
      if (mode_v6) begin
        hdr_len = IPV6_HDR_LEN;
      end else begin
        hdr_len = {b[3:0], 2'b00};
        if (b[3:0] < IPV4_MIN_IHL) bad = 1'b1;
      end
      if (mode_encap) begin
        if (p + UDP_HDR_BYTES > MAX_LEN || p < hdr_len) bad = 1'b1;
      end else if (p < hdr_len + UDP_HDR_BYTES) begin
        bad = 1'b1;
      end
    end
    hl = hdr_len;
    if (!bad) begin
      special = 1'b1;
      if (!mode_v6 && off < hl) begin
        case (off)
          2, 10: held = b;
          3: begin
            old_len = {held, b};
            w = len_step(old_len);
            step_bytes.push_back('{w[15:8], 1'b0, 1'b0});
            step_bytes.push_back('{w[7:0], 1'b0, 1'b0});
          end
          9: begin
            old_prot = b;
            if (!mode_encap && b != UDP_PROTO) bad = 1'b1;
            else step_bytes.push_back('{prot_cfg, 1'b0, 1'b0});
          end
          11: begin
            w = ones_fix({held, b}, old_len, len_step(old_len));
            if (old_prot != prot_cfg) w = ones_fix(w, {8'd0, old_prot}, {8'd0, prot_cfg});
            step_bytes.push_back('{w[15:8], 1'b0, 1'b0});
            step_bytes.push_back('{w[7:0], 1'b0, 1'b0});
          end
          default: special = 1'b0;
        endcase
      end else if (mode_v6 && off < hl) begin
        case (off)
          4: held = b;
          5: begin
            old_len = {held, b};
            w = len_step(old_len);
            step_bytes.push_back('{w[15:8], 1'b0, 1'b0});
            step_bytes.push_back('{w[7:0], 1'b0, 1'b0});
          end
          6: begin
            old_prot = b;
            if (!mode_encap && b != UDP_PROTO) bad = 1'b1;
            else step_bytes.push_back('{prot_cfg, 1'b0, 1'b0});
          end
          default: special = 1'b0;
        endcase
      end else begin
        special = 1'b0;
      end

      if (!special) begin
        if (mode_encap) begin
          step_bytes.push_back('{b, 1'b0, 1'b0});
          if (off + 1 == hl) begin
            w = 16'(total + UDP_HDR_BYTES - hl);
            step_bytes.push_back('{sport_cfg[15:8], 1'b0, 1'b0});
            step_bytes.push_back('{sport_cfg[7:0], 1'b0, 1'b0});
            step_bytes.push_back('{dport_cfg[15:8], 1'b0, 1'b0});
            step_bytes.push_back('{dport_cfg[7:0], 1'b0, 1'b0});
            step_bytes.push_back('{w[15:8], 1'b0, 1'b0});
            step_bytes.push_back('{w[7:0], 1'b0, 1'b0});
            step_bytes.push_back('{8'h00, 1'b0, 1'b0});
            step_bytes.push_back('{8'h00, 1'b0, 1'b0});
          end
        end else if (off + 1 < hl) begin
          step_bytes.push_back('{b, 1'b0, 1'b0});
        end else if (off + 1 == hl) begin
          held = b;
        end else if (off == hl + 7) begin
          // last header byte goes out at the end of the stripped header
          step_bytes.push_back('{held, 1'b0, 1'b0});
        end else if (off > hl + 7) begin
          step_bytes.push_back('{b, 1'b0, 1'b0});
        end
      end

      if (lst && (mode_encap ? off + 1 < hl : off < hl + 7)) bad = 1'b1;
    end

    if (bad) begin
      step_bytes = {DROP_RES};
      skipping = !lst;
      pos = '0;
    end else if (lst) begin
      if (step_bytes.size() > 0) step_bytes[$].olast = 1'b1;
      pos = '0;
    end else begin
      pos = (off < MAX_LEN) ? 16'(off + 1) : 16'(off);
    end
  endtask

  always @(posedge clk) begin
    in_acc  = 1'b0;
    cfg_acc = 1'b0;
    if (rst_n) begin
      if (cfg_chan.valid && cfg_chan.ready) begin
        cfg_acc = 1'b1;
        case (cfg_reg_t'(cfg_chan.index))
          CFG_ENCAP_MODE:  mode_encap = cfg_chan.data[0];
          CFG_IP_VERSION:  mode_v6    = cfg_chan.data[0];
          CFG_NEW_PROT:    prot_cfg   = cfg_chan.data[7:0];
          CFG_SOURCE_PORT: sport_cfg  = cfg_chan.data;
          CFG_DEST_PORT:   dport_cfg  = cfg_chan.data;
          default: ;
        endcase
      end
      if (in_chan.valid && in_chan.ready) begin
        in_acc = 1'b1;
        bytes_taken++;
        udp_rewrite(in_chan.data_byte, in_chan.packet_length, in_chan.last_byte);
        if (cur_typed) pending_bytes.push_back(cur_res);
        else foreach (step_bytes[i]) pending_bytes.push_back(step_bytes[i]);
      end
      if (out_chan.valid && out_chan.ready) begin
        if (pending_bytes.size() == 0) begin
          $error("unexpected result: out_byte %h out_last %b drop %b",
                 out_chan.out_byte, out_chan.out_last, out_chan.drop);
          mismatches++;
        end else begin
          seen = pending_bytes.pop_front();
          if (out_chan.out_byte !== seen.obyte) begin
            $error("out_byte: expected %h, got %h", seen.obyte, out_chan.out_byte);
            mismatches++;
          end
          if (out_chan.out_last !== seen.olast) begin
            $error("out_last: expected %b, got %b", seen.olast, out_chan.out_last);
            mismatches++;
          end
          if (out_chan.drop !== seen.odrop) begin
            $error("drop: expected %b, got %b", seen.odrop, out_chan.drop);
            mismatches++;
          end
        end
      end
    end
  end

  // result side: random stalls, or a long hold-off when asked
  initial begin
    out_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= ($urandom_range(0, 99) >= rcv_stall_pct);
      end
    end
  end

  task automatic push_byte(input logic [7:0] b, input logic [LEN_W-1:0] plen, input logic lst,
                           input logic typed, input result_t tres);
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    in_chan.valid         <= 1'b1;
    in_chan.data_byte     <= b;
    in_chan.packet_length <= plen;
    in_chan.last_byte     <= lst;
    cur_typed = typed;
    cur_res   = tres;
    @(negedge clk);
    while (!in_acc) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [15:0] val);
    cfg_chan.valid <= 1'b1;
    cfg_chan.index <= idx;
    cfg_chan.data  <= val;
    @(negedge clk);
    while (!cfg_acc) @(negedge clk);
    cfg_chan.valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic await_results();
    in_chan.valid <= 1'b0;
    while (pending_bytes.size() != 0) @(negedge clk);
  endtask

  // also covers requests still inside that give no result
  task automatic drain_block();
    await_results();
    repeat (NRES + 4) @(negedge clk);
  endtask

  task automatic send_packet();
    logic [7:0]  pkt [$];
    int unsigned r, ihl, hl, n, plen, pidx, lidx, i;
    logic [15:0] lw;
    r    = $urandom_range(0, 99);
    ihl  = ($urandom_range(0, 3) == 0) ? $urandom_range(6, 15) : 5;
    hl   = mode_v6 ? 40 : ihl * 4;
    n    = hl + (mode_encap ? 0 : 8) + $urandom_range(0, 12);
    plen = n;
    pidx = mode_v6 ? 6 : 9;
    lidx = mode_v6 ? 4 : 2;
    for (i = 0; i < n; i++) pkt.push_back(8'($urandom_range(0, 255)));
    if (!mode_v6) pkt[0][3:0] = ihl[3:0];
    if ($urandom_range(0, 3) != 0) pkt[0][7:4] = mode_v6 ? 4'h6 : 4'h4;
    if (!mode_encap) pkt[pidx] = UDP_PROTO;
    else if ($urandom_range(0, 1) == 0) pkt[pidx] = prot_cfg;
    if ($urandom_range(0, 7) == 0) begin
      // length words that wrap when patched
      case ($urandom_range(0, 3))
        0: lw = 16'h0000;
        1: lw = 16'h0007;
        2: lw = 16'hFFF8;
        default: lw = 16'hFFFF;
      endcase
      pkt[lidx]     = lw[15:8];
      pkt[lidx + 1] = lw[7:0];
    end

    if (r < 65) begin
      // well formed
    end else if (r < 75) begin
      plen = $urandom_range(0, 65535);
    end else if (r < 83) begin
      n = $urandom_range(1, hl + 8);
      if (n > pkt.size()) n = pkt.size();
    end else if (r < 88) begin
      if (!mode_v6 && $urandom_range(0, 1) == 0) pkt[0][3:0] = 4'($urandom_range(0, 4));
      else if (mode_encap) plen = ($urandom_range(0, 1) == 0) ? $urandom_range(65528, 65535)
                                                                : $urandom_range(0, hl - 1);
      else plen = $urandom_range(0, hl + 7);
    end else if (r < 94) begin
      pkt[pidx] = 8'($urandom_range(0, 255));
      if (pkt[pidx] == UDP_PROTO) pkt[pidx] = 8'h06;
    end else begin
      n = $urandom_range(1, 30);
      plen = $urandom_range(0, 65535);
      pkt.delete();
      for (i = 0; i < n; i++) pkt.push_back(8'($urandom_range(0, 255)));
    end

    for (i = 0; i < n; i++)
      push_byte(pkt[i], (i == 0) ? plen[15:0] : 16'($urandom_range(0, 65535)), i == n - 1,
                1'b0, NO_RES);
  endtask

  initial begin
    int k, ph, goal;
    rst_n                 = 1'b0;
    in_chan.valid         = 1'b0;
    in_chan.data_byte     = '0;
    in_chan.packet_length = '0;
    in_chan.last_byte     = 1'b0;
    cfg_chan.valid        = 1'b0;
    cfg_chan.index        = '0;
    cfg_chan.data         = '0;
    cur_typed             = 1'b0;
    cur_res               = NO_RES;
    in_acc                = 1'b0;
    cfg_acc               = 1'b0;
    bytes_taken           = 0;
    mismatches            = 0;
    snd_idle_pct          = 0;
    rcv_stall_pct         = 0;
    hold_req              = 1'b0;
    hold_left             = 0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (k = 0; k < N_ROWS; k++) begin
      if (DIR_ROWS[k].kind == ROW_CFG) begin
        drain_block();
        write_reg(DIR_ROWS[k].reg_idx, DIR_ROWS[k].val);
      end else begin
        push_byte(DIR_ROWS[k].b, DIR_ROWS[k].plen, DIR_ROWS[k].lst, DIR_ROWS[k].typed,
                  DIR_ROWS[k].res);
      end
    end

    for (ph = 0; ph < N_PHASES; ph++) begin
      drain_block();
      write_reg(CFG_ENCAP_MODE, (ph < 4) ? 16'(ph & 1) : 16'($urandom_range(0, 1)));
      write_reg(CFG_IP_VERSION, (ph < 4) ? 16'((ph >> 1) & 1) : 16'($urandom_range(0, 1)));
      case (ph)
        0: begin
          write_reg(CFG_NEW_PROT, 16'h0000);
          write_reg(CFG_SOURCE_PORT, 16'hFFFF);
          write_reg(CFG_DEST_PORT, 16'hFFFF);
        end
        1: begin
          write_reg(CFG_NEW_PROT, 16'h00FF);
          write_reg(CFG_SOURCE_PORT, 16'h0000);
          write_reg(CFG_DEST_PORT, 16'h0000);
        end
        default: begin
          write_reg(CFG_NEW_PROT, ($urandom_range(0, 1) == 0) ? 16'(UDP_PROTO)
                                                             : 16'($urandom_range(0, 255)));
          write_reg(CFG_SOURCE_PORT, 16'($urandom_range(0, 65535)));
          write_reg(CFG_DEST_PORT, 16'($urandom_range(0, 65535)));
        end
      endcase
      case (ph % 4)
        0: begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
        1: begin snd_idle_pct = 68; rcv_stall_pct = 0;  end
        2: begin snd_idle_pct = 0;  rcv_stall_pct = 68; end
        default: begin snd_idle_pct = 17; rcv_stall_pct = 17; end
      endcase
      // long hold-off on the result side so the input backs up
      if (ph == 0) hold_req = 1'b1;
      // the packet in progress runs past the goal, so aim a little short
      goal = bytes_taken + 45;
      while (bytes_taken < goal) begin
        send_packet();
        if (ph == 3) await_results();
      end
    end

    await_results();
    repeat (3 * NRES) @(negedge clk);
    if (mismatches == 0) begin
      $display("** udp_header_encap_decap_top: PASSED **");
    end else begin
      $display("** udp_header_encap_decap_top: FAILED **");
    end
    $finish;
  end

endmodule

### filelist.f
src/uhed_pkg.sv
src/uhed_in_if.sv
src/uhed_out_if.sv
src/uhed_cfg_if.sv
src/udp_header_encap_decap_top.sv
src/uhed_checker.sv
sim/tb_top.sv
